// File: rtl/core/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants for the dense layer with ReLU (Q8.8 fixed point).
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int DATA_W          = 16;
  localparam int FRAC_W          = 8;
  localparam int ACT_W           = 15;
  localparam int IDX_W           = 4;
  localparam int CFG_W           = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int ACC_W           = 40;
  localparam int RESULT_LIMIT    = 16;
  localparam int MAX_INPUTS_DEF  = 16;
  localparam int MAX_OUTPUTS_DEF = 16;

  localparam logic [ACT_W-1:0] ACT_MAX = {ACT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_INPUTS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_OUTPUTS = 1'b1;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_ACT    = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic last;
    logic add;
  } dlr_mac_ctl_t;

endpackage

// File: rtl/core/dlr_ifs.sv
// ----------------------------------------------------------------------------
// dlr_ifs
// Valid/ready item channels for the dense layer: command in, result out.
// ----------------------------------------------------------------------------
interface dlr_in_if import dlr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         column_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, command, row_index, column_index, data_value,
                  input ready);
  modport sink   (input valid, command, row_index, column_index, data_value,
                  output ready);
endinterface

interface dlr_out_if import dlr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] neuron_index;
  logic [ACT_W-1:0] activation;
  logic             last_neuron;

  modport source (output valid, neuron_index, activation, last_neuron,
                  input ready);
  modport sink   (input valid, neuron_index, activation, last_neuron,
                  output ready);
endinterface

// File: rtl/core/dense_layer_relu.sv
// ----------------------------------------------------------------------------
// dense_layer_relu
// Fully connected layer with ReLU, Q8.8: stores, serial MAC, result register.
// Write items are accepted while idle and give no result; input is held off during a run.
// Per row a run reads the bias, inits, then per input fetches, loads, runs the
// bit-serial multiply and accumulates, and last loads the result; rows follow back
// to back unless the result register is stalled.
// Reset (rst, synchronous) clears control, sets both sizes to 16; stores not cleared.
// ----------------------------------------------------------------------------
module dense_layer_relu import dlr_pkg::*; #(
  parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  dlr_in_if.sink               in_ch,
  dlr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int OUT_LIM  = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;
  localparam int BIT_CW   = $clog2(DATA_W);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_BIAS  = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_FETCH = 8'b0000_1000,
    S_LOAD  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_ACC   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [CFG_W-1:0]         active_inputs;
  logic [CFG_W-1:0]         active_outputs;
  logic [CFG_W-1:0]         n_in_eff;
  logic [CFG_W-1:0]         n_out_eff;
  logic [IDX_W-1:0]         row;
  logic [CFG_W-1:0]         col;
  logic [BIT_CW-1:0]        bit_cnt;
  logic                     in_acc;
  logic                     is_run;
  logic                     bit_last;
  logic                     col_last;
  logic                     row_last;
  logic                     out_load;
  logic                     out_valid;
  dlr_mac_ctl_t             mac_ctl;
  logic signed [DATA_W-1:0] weight_q;
  logic signed [DATA_W-1:0] bias_q;
  logic signed [DATA_W-1:0] act_q;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-FRAC_W-1:0]  acc_q88;
  logic [ACT_W-1:0]         relu;

  assign in_ch.ready  = (state == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_run       = in_acc && (cmd_t'(in_ch.command) == CMD_RUN);
  assign out_ch.valid = out_valid;

  always_comb begin
    n_in_eff  = (active_inputs > MAX_INPUTS) ? CFG_W'(MAX_INPUTS) : active_inputs;
    n_out_eff = (active_outputs > OUT_LIM) ? CFG_W'(OUT_LIM) : active_outputs;
    bit_last  = (bit_cnt == BIT_CW'(DATA_W - 1));
    col_last  = (col + 1'b1 == n_in_eff);
    row_last  = ({1'b0, row} + 1'b1 == n_out_eff);
    out_load  = (state == S_OUT) && (!out_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs  <= CFG_W'(16);
      active_outputs <= CFG_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_INPUTS:  active_inputs  <= cfg_data;
        REG_ACTIVE_OUTPUTS: active_outputs <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    case (state)
      S_IDLE: begin
        if (is_run && n_out_eff != '0) state_next = S_BIAS;
      end
      S_BIAS:  state_next = S_INIT;
      S_INIT: begin
        mac_ctl.init = 1'b1;
        state_next   = (n_in_eff == '0) ? S_OUT : S_FETCH;
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD: begin
        mac_ctl.load = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        mac_ctl.step = 1'b1;
        mac_ctl.last = bit_last;
        if (bit_last) state_next = S_ACC;
      end
      S_ACC: begin
        mac_ctl.add = 1'b1;
        state_next  = col_last ? S_OUT : S_FETCH;
      end
      S_OUT: begin
        if (out_load) state_next = row_last ? S_IDLE : S_BIAS;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      row     <= '0;
      col     <= '0;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE:  row <= '0;
        S_INIT:  col <= '0;
        S_LOAD:  bit_cnt <= '0;
        S_MUL:   bit_cnt <= bit_cnt + 1'b1;
        S_ACC:   col <= col + 1'b1;
        S_OUT:   if (out_load && !row_last) row <= row + 1'b1;
        default: ;
      endcase
    end
  end

  // ReLU, drop fraction, saturate
  always_comb begin
    acc_q88 = acc[ACC_W-1:FRAC_W];
    if (acc[ACC_W-1] || acc == '0) begin
      relu = '0;
    end else if (|acc_q88[ACC_W-FRAC_W-1:ACT_W]) begin
      relu = ACT_MAX;
    end else begin
      relu = acc_q88[ACT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.neuron_index <= row;
      out_ch.activation   <= relu;
      out_ch.last_neuron  <= row_last;
    end
  end

  dlr_store #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_store (
    .clk          (clk),
    .wr_en        (in_acc),
    .command      (cmd_t'(in_ch.command)),
    .row_index    (in_ch.row_index),
    .column_index (in_ch.column_index),
    .data_value   (in_ch.data_value),
    .rd_row       (row),
    .rd_col       (col),
    .weight_q     (weight_q),
    .bias_q       (bias_q),
    .act_q        (act_q)
  );

  dlr_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .act_q    (act_q),
    .weight_q (weight_q),
    .bias_q   (bias_q),
    .acc      (acc)
  );

`ifndef NO_ASSERTIONS
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (is_run && n_out_eff != '0) |=> (state == S_BIAS))
    else $error("run item did not start a row");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (col < n_in_eff))
    else $error("column beyond active inputs");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (out_load && !row_last) |=> (row == $past(row) + 1'b1) && (state == S_BIAS))
    else $error("row did not advance after result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && row_last) |=> (state == S_IDLE) && out_ch.last_neuron)
    else $error("final result not marked or block not idle");
`endif

endmodule

// File: rtl/core/dlr_store.sv
// ----------------------------------------------------------------------------
// dlr_store
// Weight, bias and activation memories; one write port, registered reads.
// ----------------------------------------------------------------------------
module dlr_store import dlr_pkg::*; #(
  parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  cmd_t                     command,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         column_index,
  input  logic signed [DATA_W-1:0] data_value,
  input  logic [IDX_W-1:0]         rd_row,
  input  logic [CFG_W-1:0]         rd_col,
  output logic signed [DATA_W-1:0] weight_q,
  output logic signed [DATA_W-1:0] bias_q,
  output logic signed [DATA_W-1:0] act_q
);

  localparam int W_DEPTH = MAX_OUTPUTS * MAX_INPUTS;
  localparam int IW      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

  logic signed [DATA_W-1:0] weight_mem [W_DEPTH];
  logic signed [DATA_W-1:0] bias_mem   [MAX_OUTPUTS];
  logic signed [DATA_W-1:0] act_mem    [MAX_INPUTS];

  logic [WAW-1:0] wr_w_addr;
  logic [WAW-1:0] rd_w_addr;
  logic           row_ok;
  logic           col_ok;

  assign row_ok    = row_index < MAX_OUTPUTS;
  assign col_ok    = column_index < MAX_INPUTS;
  assign wr_w_addr = WAW'(row_index) * WAW'(MAX_INPUTS) + WAW'(column_index);
  assign rd_w_addr = WAW'(rd_row) * WAW'(MAX_INPUTS) + WAW'(rd_col);

  always_ff @(posedge clk) begin
    if (wr_en && command == CMD_WEIGHT && row_ok && col_ok) begin
      weight_mem[wr_w_addr] <= data_value;
    end
    weight_q <= weight_mem[rd_w_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && command == CMD_BIAS && row_ok) begin
      bias_mem[OW'(row_index)] <= data_value;
    end
    bias_q <= bias_mem[OW'(rd_row)];
  end

  always_ff @(posedge clk) begin
    if (wr_en && command == CMD_ACT && col_ok) begin
      act_mem[IW'(column_index)] <= data_value;
    end
    act_q <= act_mem[IW'(rd_col)];
  end

endmodule

// File: rtl/core/dlr_mac.sv
// ----------------------------------------------------------------------------
// dlr_mac
// Bit-serial signed multiply (one weight bit per cycle) and accumulator.
// ----------------------------------------------------------------------------
module dlr_mac import dlr_pkg::*; (
  input  logic                     clk,
  input  dlr_mac_ctl_t             ctl,
  input  logic signed [DATA_W-1:0] act_q,
  input  logic signed [DATA_W-1:0] weight_q,
  input  logic signed [DATA_W-1:0] bias_q,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [DATA_W-1:0]   mcand;
  logic [DATA_W-1:0]          mplier;
  logic signed [DATA_W:0]     hi;
  logic [DATA_W-1:0]          lo;
  logic signed [DATA_W:0]     mcand_ext;
  logic signed [DATA_W:0]     term;
  logic signed [DATA_W+1:0]   sum;
  logic signed [2*DATA_W:0]   product;

  always_comb begin
    mcand_ext = {mcand[DATA_W-1], mcand};
    if (!mplier[0]) begin
      term = '0;
    end else if (ctl.last) begin
      term = -mcand_ext;                // sign bit of the weight has negative weight
    end else begin
      term = mcand_ext;
    end
    sum     = {hi[DATA_W], hi} + {term[DATA_W], term};
    product = {hi, lo};
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc <= {{(ACC_W-DATA_W-FRAC_W){bias_q[DATA_W-1]}}, bias_q, {FRAC_W{1'b0}}};
    end else if (ctl.add) begin
      acc <= acc + {{(ACC_W-2*DATA_W-1){product[2*DATA_W]}}, product};
    end
    if (ctl.load) begin
      mcand  <= act_q;
      mplier <= weight_q;
      hi     <= '0;
      lo     <= '0;
    end else if (ctl.step) begin
      hi     <= sum[DATA_W+1:1];
      lo     <= {sum[0], lo[DATA_W-1:1]};
      mplier <= mplier >> 1;
    end
  end

endmodule
